// ===== design/segpd_pkg.sv =====
// Shared constants for the segment pair distance pipeline.
package segpd_pkg;

  // Width of the distance result word and its saturation value
  localparam int unsigned DIST_W = 26;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

// ===== design/segpd_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
module segpd_div #(
  parameter int unsigned DW = 31,
  parameter int unsigned QW = 51
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,   // upper dividend bits, must be below den_i
  input  logic [QW-1:0] low_i,   // lower dividend bits, MSB first
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] low_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] lin;
    logic [DW:0]   t;
    logic          ge;

    if (s == 0) begin : g_first
      assign rin = rem_i;
      assign din = den_i;
      assign lin = low_i;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign din = den_q[s-1];
      assign lin = low_q[s-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign t  = {rin, lin[QW-1]};
    assign ge = t >= {1'b0, din};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[s] <= {lin[QW-2:0], ge};
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? DW'(t - {1'b0, din}) : DW'(t);
          den_q[s] <= din;
        end
      end
    end
  end

  assign quo_o = low_q[QW-1];

endmodule

// ===== design/segpd_sqrt.sv =====
// Pipelined integer square root: one root bit per register stage.
module segpd_sqrt #(
  parameter int unsigned RW = 26
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] x_i,
  output logic [RW-1:0]   root_o
);

  localparam int unsigned XW = 2 * RW;

  logic [RW:0]   rem_q  [RW-1];
  logic [XW-1:0] x_q    [RW-1];
  logic [RW-1:0] root_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_st
    logic [RW:0]   rin;
    logic [RW-1:0] oin;
    logic [XW-1:0] xin;
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rin = '0;
      assign oin = '0;
      assign xin = x_i;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign oin = root_q[s-1];
      assign xin = x_q[s-1];
    end

    // bring down two radicand bits, try root*4+1
    assign t     = {rin, xin[XW-1 -: 2]};
    assign trial = {1'b0, oin, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= {oin[RW-2:0], ge};
      end
    end

    if (s < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? (RW+1)'(t - trial) : (RW+1)'(t);
          x_q[s]   <= xin << 2;
        end
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== design/segment_pair_min_distance.sv =====
// Top level: least distance between two 2-D integer segments, fully pipelined.
//
//  channel  | dir | tdata fields (LSB first)                          | tuser
//  s_axis   | in  | seg1_start_x/y, seg1_end_x/y, seg2_start_x/y,    | -
//           |     | seg2_end_x/y, COORD_BITS each, signed             |
//  m_axis   | out | distance_q10 (26), zero pad to 32                 | segments_touch
//
// One word in and one word out per cycle while m_axis_tready holds. An accepted word passes
// through stages 1 to 5, the divider lanes, the minimum stages and the square root into
// the output register, with QW = 2*COORD_BITS+1+2*FRAC_BITS (divider lanes, one quotient
// bit a stage) and RW = COORD_BITS+FRAC_BITS+1 (square root, one root bit a stage).
// All stages advance together when the output register is empty or being taken;
// a stall freezes every stage. Reset clears only the valid bits.
module segment_pair_min_distance
  import segpd_pkg::*;
#(
  parameter int unsigned COORD_BITS = 15,
  parameter int unsigned FRAC_BITS  = 10
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // distance_q10, zero pad
  output logic [((segpd_pkg::DIST_W+7)/8)*8-1:0]  m_axis_tdata,
  // segments_touch
  output logic                                    m_axis_tuser
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned DFW  = CW + 1;
  localparam int unsigned PW   = 2 * CW + 2;
  localparam int unsigned SW   = 2 * CW + 1;
  localparam int unsigned C2W  = 2 * SW;
  localparam int unsigned QW   = 2 * CW + 1 + 2 * FRAC_BITS;
  localparam int unsigned RW   = CW + FRAC_BITS + 1;
  localparam int unsigned XW   = 2 * RW;
  localparam int unsigned TDO  = ((DIST_W + 7) / 8) * 8;
  localparam int unsigned NST  = 8 + QW + RW;

  typedef struct packed {
    logic          touch;
    logic [3:0]    ok;
    logic [SW-1:0] pmin;
  } side_t;

  logic en;
  logic [NST-1:0] vld_q;

  // whole pipe moves when the output register can take a word
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // point coordinates
  logic signed [CW-1:0] pt_x [4];
  logic signed [CW-1:0] pt_y [4];
  for (genvar i = 0; i < 4; i++) begin : g_pt
    assign pt_x[i] = s_axis_tdata[2*i*CW +: CW];
    assign pt_y[i] = s_axis_tdata[(2*i+1)*CW +: CW];
  end

  // Stage 1: differences and bounding box tests.
  // Foot f projects point f onto the other segment (points a, a+1).
  logic signed [DFW-1:0] ux_q [4], uy_q [4], vx_q [4], vy_q [4];
  logic signed [DFW-1:0] dx_q [4], dy_q [4];
  logic [3:0] win1_q;

  for (genvar f = 0; f < 4; f++) begin : g_s1
    localparam int unsigned A = (f < 2) ? 2 : 0;
    localparam int unsigned I = f / 2;
    localparam int unsigned J = 2 + (f % 2);
    always_ff @(posedge clk_i) begin
      if (en) begin
        ux_q[f]   <= DFW'(pt_x[A+1]) - DFW'(pt_x[A]);
        uy_q[f]   <= DFW'(pt_y[A+1]) - DFW'(pt_y[A]);
        vx_q[f]   <= DFW'(pt_x[f]) - DFW'(pt_x[A]);
        vy_q[f]   <= DFW'(pt_y[f]) - DFW'(pt_y[A]);
        dx_q[f]   <= DFW'(pt_x[I]) - DFW'(pt_x[J]);
        dy_q[f]   <= DFW'(pt_y[I]) - DFW'(pt_y[J]);
        win1_q[f] <= ((pt_x[f] >= pt_x[A]) || (pt_x[f] >= pt_x[A+1])) &&
                     ((pt_x[f] <= pt_x[A]) || (pt_x[f] <= pt_x[A+1])) &&
                     ((pt_y[f] >= pt_y[A]) || (pt_y[f] >= pt_y[A+1])) &&
                     ((pt_y[f] <= pt_y[A]) || (pt_y[f] <= pt_y[A+1]));
      end
    end
  end

  // Stage 2: products
  logic signed [PW-1:0] uxux_q [4], uyuy_q [4], uxvx_q [4], uyvy_q [4];
  logic signed [PW-1:0] uxvy_q [4], uyvx_q [4], dxdx_q [4], dydy_q [4];
  logic [3:0] win2_q;

  for (genvar f = 0; f < 4; f++) begin : g_s2
    always_ff @(posedge clk_i) begin
      if (en) begin
        uxux_q[f] <= PW'(ux_q[f]) * PW'(ux_q[f]);
        uyuy_q[f] <= PW'(uy_q[f]) * PW'(uy_q[f]);
        uxvx_q[f] <= PW'(ux_q[f]) * PW'(vx_q[f]);
        uyvy_q[f] <= PW'(uy_q[f]) * PW'(vy_q[f]);
        uxvy_q[f] <= PW'(ux_q[f]) * PW'(vy_q[f]);
        uyvx_q[f] <= PW'(uy_q[f]) * PW'(vx_q[f]);
        dxdx_q[f] <= PW'(dx_q[f]) * PW'(dx_q[f]);
        dydy_q[f] <= PW'(dy_q[f]) * PW'(dy_q[f]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      win2_q <= win1_q;
    end
  end

  // Stage 3: length, endpoint distance, dot and cross sums
  logic [SW-1:0]        len3_q [4];
  logic [SW-1:0]        d2_q   [4];
  logic signed [PW-1:0] dot_q  [4];
  logic signed [PW-1:0] cr_q   [4];
  logic [3:0] win3_q;

  for (genvar f = 0; f < 4; f++) begin : g_s3
    always_ff @(posedge clk_i) begin
      if (en) begin
        len3_q[f] <= SW'(uxux_q[f] + uyuy_q[f]);
        d2_q[f]   <= SW'(dxdx_q[f] + dydy_q[f]);
        dot_q[f]  <= uxvx_q[f] + uyvy_q[f];
        cr_q[f]   <= uxvy_q[f] - uyvx_q[f];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      win3_q <= win2_q;
    end
  end

  // Stage 4: foot validity, orientation signs, contact test, point minima
  logic [3:0] neg, zer, ok4;
  logic       touch4;
  logic [SW-1:0] acr_q [4];
  logic [SW-1:0] len4_q [4];
  logic [3:0]    ok4_q;
  logic          touch4_q;
  logic [SW-1:0] m01_q, m23_q;

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      neg[f] = cr_q[f][PW-1];
      zer[f] = cr_q[f] == '0;
      ok4[f] = (len3_q[f] != '0) && !dot_q[f][PW-1] && (SW'(dot_q[f]) <= len3_q[f]);
    end
    // strict crossing, or an endpoint on the other segment
    touch4 = (((neg[0] && !neg[1] && !zer[1]) || (neg[1] && !neg[0] && !zer[0])) &&
              ((neg[2] && !neg[3] && !zer[3]) || (neg[3] && !neg[2] && !zer[2]))) ||
             ((zer & win3_q) != 4'b0);
  end

  for (genvar f = 0; f < 4; f++) begin : g_s4
    always_ff @(posedge clk_i) begin
      if (en) begin
        acr_q[f]  <= cr_q[f][PW-1] ? SW'(-cr_q[f]) : SW'(cr_q[f]);
        len4_q[f] <= len3_q[f];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok4_q    <= ok4;
      touch4_q <= touch4;
      m01_q    <= (d2_q[1] < d2_q[0]) ? d2_q[1] : d2_q[0];
      m23_q    <= (d2_q[3] < d2_q[2]) ? d2_q[3] : d2_q[2];
    end
  end

  // Stage 5: squared cross product
  logic [C2W-1:0] cr2_q  [4];
  logic [SW-1:0]  len5_q [4];
  side_t          side5_q;

  for (genvar f = 0; f < 4; f++) begin : g_s5
    always_ff @(posedge clk_i) begin
      if (en) begin
        cr2_q[f]  <= C2W'(acr_q[f]) * C2W'(acr_q[f]);
        len5_q[f] <= len4_q[f];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q.touch <= touch4_q;
      side5_q.ok    <= ok4_q;
      side5_q.pmin  <= (m23_q < m01_q) ? m23_q : m01_q;
    end
  end

  // Divider lanes: cross^2 * 4^F / len2 for each foot
  logic [QW-1:0] quo [4];

  for (genvar f = 0; f < 4; f++) begin : g_div
    segpd_div #(
      .DW(SW),
      .QW(QW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (cr2_q[f][C2W-1:SW]),
      .low_i (QW'(cr2_q[f][SW-1:0]) << (2 * FRAC_BITS)),
      .den_i (len5_q[f]),
      .quo_o (quo[f])
    );
  end

  // sideband alongside the divider stages
  side_t side_q [QW];
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side5_q;
      for (int s = 1; s < QW; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Minimum over squared scaled candidates, three stages
  logic [QW-1:0] qm [4];
  logic [QW-1:0] pq;
  logic [QW-1:0] ma_q, mb_q, mc_q, me_q, mc2_q, qmin_q;
  logic [RW+2:0] tt_q;

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      qm[f] = side_q[QW-1].ok[f] ? quo[f] : '1;
    end
    pq = QW'(side_q[QW-1].pmin) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q   <= (qm[1] < qm[0]) ? qm[1] : qm[0];
      mb_q   <= (qm[3] < qm[2]) ? qm[3] : qm[2];
      mc_q   <= pq;
      me_q   <= (mb_q < ma_q) ? mb_q : ma_q;
      mc2_q  <= mc_q;
      qmin_q <= (mc2_q < me_q) ? mc2_q : me_q;
      tt_q   <= {tt_q[RW+1:0], side_q[QW-1].touch};
    end
  end

  // Square root of the smallest candidate
  logic [RW-1:0] root;

  segpd_sqrt #(
    .RW(RW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (XW'(qmin_q)),
    .root_o (root)
  );

  // Output register: zero when touching, else the root with saturation
  logic              out_vld_q;
  logic [DIST_W-1:0] dist_q;
  logic              touch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      touch_q <= tt_q[RW+2];
      if (tt_q[RW+2]) begin
        dist_q <= '0;
      end else if (root > RW'(DIST_MAX)) begin
        dist_q <= DIST_MAX;
      end else begin
        dist_q <= DIST_W'(root);
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDO'(dist_q);
  assign m_axis_tuser  = touch_q;

  // Checks
  a_touch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> dist_q == '0)
    else $error("touching segments with nonzero distance");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted word missing from first stage");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !vld_q[NST-1] |=> !m_axis_tvalid)
    else $error("output word repeated");

endmodule
